[src/irlp_pkg.sv]
`default_nettype none

package irlp_pkg;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned OUT_ID_W = 32;
    localparam int unsigned DIGIT_W  = 4;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CH_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;

endpackage

`default_nettype wire

[src/irlp_chan_if.sv]
`default_nettype none

interface irlp_chr_if;
    logic                        valid;
    logic                        ready;
    logic [irlp_pkg::CH_W-1:0]   ch;
    logic                        last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

interface irlp_rng_if;
    logic                          valid;
    logic                          ready;
    logic                          range_valid;
    logic [irlp_pkg::OUT_ID_W-1:0] range_low;
    logic [irlp_pkg::OUT_ID_W-1:0] range_high;
    logic                          done_res;
    logic                          error;

    modport source (output valid, output range_valid, output range_low, output range_high,
                    output done_res, output error, input ready);
    modport sink (input valid, input range_valid, input range_low, input range_high,
                  input done_res, input error, output ready);
endinterface

`default_nettype wire

[src/irlp_digit.sv]
`default_nettype none

module irlp_digit #(
    parameter int unsigned ID_BITS = 32
) (
    input  wire logic [ID_BITS-1:0]               acc,
    input  wire logic [irlp_pkg::DIGIT_W-1:0]     digit,
    output logic      [ID_BITS-1:0]               sum,
    output logic                                  overflow
);

    localparam int unsigned WIDE_W = ID_BITS + 4;

    logic [WIDE_W-1:0] acc_wide;
    logic [WIDE_W-1:0] wide;

    // acc * 10 + digit, carried wide enough that nothing is lost
    assign acc_wide = WIDE_W'(acc);
    assign wide     = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(digit);
    assign sum      = wide[ID_BITS-1:0];
    assign overflow = |wide[WIDE_W-1:ID_BITS];

endmodule

`default_nettype wire

[src/irlp_core.sv]
`default_nettype none

module irlp_core #(
    parameter int unsigned ID_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [irlp_pkg::CH_W-1:0]     ch,
    input  wire logic                          last,
    output logic                               free,
    irlp_rng_if.source                         ranges
);

    typedef enum logic [1:0] {
        PH_BETWEEN,
        PH_FIRST,
        PH_DASH,
        PH_SECOND
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [ID_BITS-1:0]   first_reg, first_next;
    logic [ID_BITS-1:0]   cur_reg, cur_next;
    logic                 start_reg, start_next;
    logic                 close_reg, close_next;
    logic                 failed_reg, failed_next;
    logic                 stopped_reg, stopped_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            rv_reg;
    logic [irlp_pkg::OUT_ID_W-1:0]   lo_reg;
    logic [irlp_pkg::OUT_ID_W-1:0]   hi_reg;
    logic                            done_reg;
    logic                            err_reg;

    logic [irlp_pkg::DIGIT_W-1:0]    digit;
    logic [ID_BITS-1:0]              acc_sum;
    logic                            acc_ovf;

    logic                 active;
    logic                 is_digit;
    logic                 tk_comma;
    phase_t               tk_phase;
    logic [ID_BITS-1:0]   tk_first;
    logic [ID_BITS-1:0]   tk_cur;
    logic                 tk_failed;
    logic                 fin;
    logic                 have;
    logic                 emit;
    logic [ID_BITS-1:0]   lo;
    logic [ID_BITS-1:0]   hi;

    assign digit    = irlp_pkg::DIGIT_W'(ch - irlp_pkg::CH_ZERO);
    assign is_digit = ch inside {[irlp_pkg::CH_ZERO:irlp_pkg::CH_NINE]};

    irlp_digit #(
        .ID_BITS (ID_BITS)
    ) u_digit (
        .acc      (cur_reg),
        .digit    (digit),
        .sum      (acc_sum),
        .overflow (acc_ovf)
    );

    always_comb
    begin
        active       = !stopped_reg && !failed_reg;
        tk_phase     = phase_reg;
        tk_first     = first_reg;
        tk_cur       = cur_reg;
        tk_failed    = failed_reg;
        tk_comma     = 1'b0;
        start_next   = start_reg;
        close_next   = close_reg;
        stopped_next = stopped_reg;

        if (active && ch == irlp_pkg::CH_NUL)
        begin
            stopped_next = 1'b1;
        end
        else if (active)
        begin
            if (close_reg)
            begin
                tk_failed = 1'b1;
            end
            else if (start_reg && ch == irlp_pkg::CH_LBRACK)
            begin
                start_next = 1'b0;
            end
            else
            begin
                start_next = 1'b0;
                if (ch == irlp_pkg::CH_RBRACK)
                begin
                    close_next = 1'b1;
                end
                else if (ch == irlp_pkg::CH_COMMA)
                begin
                    tk_comma = 1'b1;
                end
                else if (is_digit)
                begin
                    if (phase_reg == PH_BETWEEN || phase_reg == PH_DASH)
                    begin
                        tk_phase = (phase_reg == PH_BETWEEN) ? PH_FIRST : PH_SECOND;
                        tk_cur   = ID_BITS'(digit);
                    end
                    else if (acc_ovf)
                    begin
                        tk_failed = 1'b1;
                    end
                    else
                    begin
                        tk_cur = acc_sum;
                    end
                end
                else if (ch == irlp_pkg::CH_DASH && phase_reg == PH_FIRST)
                begin
                    tk_first = cur_reg;
                    tk_cur   = '0;
                    tk_phase = PH_DASH;
                end
                else
                begin
                    tk_failed = 1'b1;
                end
            end
        end

        // close the open token on NUL, on a comma, or at the end of the string
        fin = active && (ch == irlp_pkg::CH_NUL || tk_comma || (last && !tk_failed));

        phase_next  = fin ? PH_BETWEEN : tk_phase;
        first_next  = tk_first;
        cur_next    = tk_cur;
        failed_next = tk_failed || (fin && tk_phase == PH_DASH);
        have        = fin && (tk_phase == PH_FIRST || tk_phase == PH_SECOND);

        if (tk_phase == PH_SECOND && tk_cur < tk_first)
        begin
            lo = tk_cur;
            hi = tk_first;
        end
        else if (tk_phase == PH_SECOND)
        begin
            lo = tk_first;
            hi = tk_cur;
        end
        else
        begin
            lo = tk_cur;
            hi = tk_cur;
        end

        emit = have || last;

        if (last)
        begin
            phase_next   = PH_BETWEEN;
            first_next   = '0;
            cur_next     = '0;
            start_next   = 1'b1;
            close_next   = 1'b0;
            failed_next  = 1'b0;
            stopped_next = 1'b0;
        end
    end

    assign free = !out_valid_reg || ranges.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (ranges.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BETWEEN;
            first_reg     <= '0;
            cur_reg       <= '0;
            start_reg     <= 1'b1;
            close_reg     <= 1'b0;
            failed_reg    <= 1'b0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                phase_reg   <= phase_next;
                first_reg   <= first_next;
                cur_reg     <= cur_next;
                start_reg   <= start_next;
                close_reg   <= close_next;
                failed_reg  <= failed_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            rv_reg   <= have && !failed_next;
            lo_reg   <= have ? irlp_pkg::OUT_ID_W'(lo) : '0;
            hi_reg   <= have ? irlp_pkg::OUT_ID_W'(hi) : '0;
            done_reg <= last;
            err_reg  <= last && (tk_failed || (fin && tk_phase == PH_DASH));
        end
    end

    assign ranges.valid       = out_valid_reg;
    assign ranges.range_valid = rv_reg;
    assign ranges.range_low   = lo_reg;
    assign ranges.range_high  = hi_reg;
    assign ranges.done_res    = done_reg;
    assign ranges.error       = err_reg;

endmodule

`default_nettype wire

[src/id_range_list_parser.sv]
// Each character waits in an input register; its result is registered in the output stage.
// One character per cycle while no result stalls; a step is a x10 accumulate and a compare.
// Characters that complete no token and do not end the string give no result transaction.
// Reset: rst_n, asynchronous and active low, empties both stages and returns the
// parser to the start of a string.
`default_nettype none

module id_range_list_parser #(
    parameter int unsigned ID_BITS = 32
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    irlp_chr_if.sink     chars,
    irlp_rng_if.source   ranges
);

    logic                          in_valid_reg, in_valid_next;
    logic [irlp_pkg::CH_W-1:0]     ch_reg;
    logic                          last_reg;
    logic                          free;
    logic                          advance;

    assign advance     = in_valid_reg && free;
    assign chars.ready = !in_valid_reg || free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (chars.valid && chars.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // hold the character until the parser takes it
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            ch_reg   <= chars.ch;
            last_reg <= chars.last;
        end
    end

    irlp_core #(
        .ID_BITS (ID_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ch     (ch_reg),
        .last   (last_reg),
        .free   (free),
        .ranges (ranges)
    );

endmodule

`default_nettype wire

[tb/sv/id_range_list_parser_tb.sv]
`timescale 1ns / 1ps

module id_range_list_parser_tb;
    import irlp_pkg::*;

    localparam int unsigned ID_W           = 32;
    localparam int          RANDOM_ITEMS   = 1950;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DRAIN_CYCLES   = 8;

    typedef logic [CH_W-1:0] chr_q_t[$];

    typedef struct {
        logic                rv;
        logic [OUT_ID_W-1:0] lo;
        logic [OUT_ID_W-1:0] hi;
        logic                done;
        logic                err;
    } range_res_t;

    typedef enum logic [1:0] {
        TOK_NONE,
        TOK_FIRST,
        TOK_DASH,
        TOK_SECOND
    } tok_phase_t;

    class range_scoreboard #(int unsigned IDW = 32);
        range_res_t  expected_q[$];
        int          mismatches;
        tok_phase_t  phase;
        logic [63:0] first_num;
        logic [63:0] cur_num;
        bit          at_start;
        bit          close_pend;
        bit          failed;
        bit          stopped;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            phase      = TOK_NONE;
            first_num  = '0;
            cur_num    = '0;
            at_start   = 1'b1;
            close_pend = 1'b0;
            failed     = 1'b0;
            stopped    = 1'b0;
        endfunction

        function logic [63:0] id_limit();
            return (IDW >= 64) ? '1 : ((64'd1 << IDW) - 64'd1);
        endfunction

        function bit end_token(output logic [63:0] lo, output logic [63:0] hi);
            tok_phase_t p;
            p     = phase;
            phase = TOK_NONE;
            lo    = '0;
            hi    = '0;
            if (p == TOK_FIRST) begin
                lo = cur_num;
                hi = cur_num;
                return 1'b1;
            end
            if (p == TOK_SECOND) begin
                lo = (cur_num >= first_num) ? first_num : cur_num;
                hi = (cur_num >= first_num) ? cur_num : first_num;
                return 1'b1;
            end
            if (p == TOK_DASH)
                failed = 1'b1;
            return 1'b0;
        endfunction

        function bit take_char(logic [CH_W-1:0] c, output logic [63:0] lo,
                               output logic [63:0] hi);
            logic [63:0] d;
            lo = '0;
            hi = '0;
            if (close_pend) begin
                failed = 1'b1;
                return 1'b0;
            end
            if (at_start) begin
                at_start = 1'b0;
                if (c == CH_LBRACK)
                    return 1'b0;
            end
            if (c == CH_RBRACK) begin
                close_pend = 1'b1;
                return 1'b0;
            end
            if (c == CH_COMMA)
                return end_token(lo, hi);
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = 64'(c - CH_ZERO);
                if (phase == TOK_NONE || phase == TOK_DASH) begin
                    phase   = (phase == TOK_NONE) ? TOK_FIRST : TOK_SECOND;
                    cur_num = d;
                    if (d > id_limit())
                        failed = 1'b1;
                end
                else if (cur_num > (id_limit() - d) / 10)
                    failed = 1'b1;
                else
                    cur_num = cur_num * 10 + d;
                return 1'b0;
            end
            if (c == CH_DASH && phase == TOK_FIRST) begin
                first_num = cur_num;
                cur_num   = '0;
                phase     = TOK_DASH;
                return 1'b0;
            end
            failed = 1'b1;
            return 1'b0;
        endfunction

        // Returns 1 when the character is parsed rather than ignored.
        function bit note_char(logic [CH_W-1:0] c, logic last);
            bit          have;
            bit          live;
            logic [63:0] lo;
            logic [63:0] hi;
            range_res_t  r;
            have = 1'b0;
            lo   = '0;
            hi   = '0;
            live = !stopped && !failed;
            if (live) begin
                if (c == CH_NUL) begin
                    stopped = 1'b1;
                    have    = end_token(lo, hi);
                end
                else begin
                    have = take_char(c, lo, hi);
                    if (last && !failed && !have)
                        have = end_token(lo, hi);
                end
            end
            if (failed)
                have = 1'b0;
            if (have || last) begin
                r.rv   = have;
                r.lo   = have ? lo[OUT_ID_W-1:0] : '0;
                r.hi   = have ? hi[OUT_ID_W-1:0] : '0;
                r.done = last;
                r.err  = last && failed;
                expected_q.push_back(r);
            end
            if (last)
                clear();
            return live;
        endfunction

        task report(string msg);
            $display("%0t ns: range mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(range_res_t got);
            range_res_t want;
            if (expected_q.size() == 0) begin
                report("result transaction with none expected");
                return;
            end
            want = expected_q.pop_front();
            if (got.rv !== want.rv)
                report($sformatf("range_valid got %0b want %0b", got.rv, want.rv));
            if (got.lo !== want.lo)
                report($sformatf("range_low got %0d want %0d", got.lo, want.lo));
            if (got.hi !== want.hi)
                report($sformatf("range_high got %0d want %0d", got.hi, want.hi));
            if (got.done !== want.done)
                report($sformatf("done_res got %0b want %0b", got.done, want.done));
            if (got.err !== want.err)
                report($sformatf("error got %0b want %0b", got.err, want.err));
        endtask
    endclass

    logic clk;
    logic rst_n;

    irlp_chr_if chars();
    irlp_rng_if ranges();

    id_range_list_parser #(
        .ID_BITS(ID_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .ranges(ranges)
    );

    range_scoreboard #(ID_W) sb;
    int         items_taken = 0;
    int         idle_cycles = 0;
    bit         in_acc;
    bit         out_acc;
    range_res_t got;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CH_W-1:0] noise_char();
        string pool;
        pool = "0123456789,-[] ";
        if ($urandom_range(0, 1))
            return CH_W'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic string num_text();
        logic [63:0] v;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 45)
            v = $urandom_range(0, 999);
        else if (r < 70)
            v = $urandom();
        else if (r < 80)
            v = 64'hFFFF_FFFF - $urandom_range(0, 1);
        else if (r < 87)
            v = 64'h1_0000_0000 + $urandom_range(0, 9);
        else if (r < 92)
            v = {$urandom(), $urandom()};
        else
            v = '0;
        return ($urandom_range(0, 9) == 0) ? {"0", $sformatf("%0d", v)}
                                           : $sformatf("%0d", v);
    endfunction

    function automatic chr_q_t make_text();
        chr_q_t t;
        string  s;
        int     sub;
        int     pos;
        int     ntok;
        bit     opened;
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 8))
                t.push_back(noise_char());
            return t;
        end
        opened = $urandom_range(0, 1);
        if (opened)
            t.push_back(CH_LBRACK);
        ntok = $urandom_range(1, 4);
        for (int i = 0; i < ntok; i++) begin
            if (i > 0)
                t.push_back(CH_COMMA);
            sub = $urandom_range(0, 19);
            if (sub == 0)
                continue;
            s = num_text();
            if (sub == 1)
                s = {s, "-"};
            else if (sub >= 11)
                s = {s, "-", num_text()};
            foreach (s[j])
                t.push_back(s[j]);
        end
        if ($urandom_range(0, 9) == 0)
            t.push_back(CH_COMMA);
        if (opened ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0))
            t.push_back(CH_RBRACK);
        if (t.size() == 0)
            t.push_back(CH_NUL);
        if ($urandom_range(0, 5) == 0)
            t[$urandom_range(0, t.size() - 1)] = noise_char();
        if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, t.size() - 1);
            t.insert(pos, CH_NUL);
            repeat ($urandom_range(0, 3))
                t.push_back(noise_char());
        end
        return t;
    endfunction

    // Called at a falling edge; returns at the falling edge after the last transaction.
    task automatic send_text(input chr_q_t txt, input bit calm);
        int gap;
        for (int i = 0; i < txt.size(); i++) begin
            gap = calm ? 0 : pick_gap();
            if (gap > 0) begin
                chars.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            chars.valid <= 1'b1;
            chars.ch    <= txt[i];
            chars.last  <= (i == txt.size() - 1);
            do
                @(posedge clk);
            while (!chars.ready);
            @(negedge clk);
        end
    endtask

    task automatic send_str(input string s);
        chr_q_t q;
        foreach (s[i])
            q.push_back(s[i]);
        send_text(q, 1'b0);
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            in_acc  = chars.valid && chars.ready;
            out_acc = ranges.valid && ranges.ready;
            if (in_acc) begin
                void'(sb.note_char(chars.ch, chars.last));
                items_taken++;
            end
            if (out_acc) begin
                got.rv   = ranges.range_valid;
                got.lo   = ranges.range_low;
                got.hi   = ranges.range_high;
                got.done = ranges.done_res;
                got.err  = ranges.error;
                sb.check_result(got);
            end
            if (in_acc || out_acc)
                idle_cycles = 0;
            else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("[id_range_list_parser] ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        int stall;
        ranges.ready = 1'b0;
        forever begin
            stall = pick_gap();
            @(negedge clk);
            ranges.ready <= (stall == 0);
            if (stall == 0)
                stall = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            repeat (stall - 1) @(negedge clk);
        end
    end

    initial begin
        chr_q_t txt;
        int     base;
        int     n_text;
        sb          = new();
        chars.valid = 1'b0;
        chars.ch    = '0;
        chars.last  = 1'b0;
        rst_n       = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_str("[1-3,5]");
        send_str("9-2");
        send_str("4294967296");
        send_str("-5");
        txt = '{8'h35, CH_NUL, 8'hFF};
        send_text(txt, 1'b0);
        txt = '{CH_RBRACK, 8'hFF};
        send_text(txt, 1'b0);

        base   = items_taken;
        n_text = 0;
        while (items_taken < base + RANDOM_ITEMS) begin
            // Hold off until every pending range has drained.
            if (n_text % 40 == 10) begin
                chars.valid <= 1'b0;
                while (sb.expected_q.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            send_text(make_text(), $urandom_range(0, 4) == 0);
            n_text++;
        end

        chars.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[id_range_list_parser] OK");
        else
            $display("[id_range_list_parser] ERROR");
        $finish;
    end

endmodule

[files.f]
src/irlp_pkg.sv
src/irlp_chan_if.sv
src/irlp_digit.sv
src/irlp_core.sv
src/id_range_list_parser.sv
tb/sv/id_range_list_parser_tb.sv
